[sv/psbo_pkg.sv]
`timescale 1ns / 1ps

package psbo_pkg;

   localparam int unsigned SeqWidth    = 64;
   localparam int unsigned AccWidth    = 10;
   localparam int unsigned PayWidth    = 16;
   localparam int unsigned CountWidth  = 63;
   localparam int unsigned StatusWidth = 2;
   localparam int unsigned UnitShift   = 9;   // increment unit is 512
   localparam int unsigned IncWidth    = AccWidth + UnitShift;
   localparam int unsigned DivBits     = SeqWidth - UnitShift;
   localparam int unsigned DivCntWidth = 6;
   localparam int unsigned CsrIdxWidth = 4;

   localparam logic [StatusWidth-1:0] StatusAligned = 2'd0;
   localparam logic [StatusWidth-1:0] StatusLowered = 2'd1;
   localparam logic [StatusWidth-1:0] StatusRaised  = 2'd2;
   localparam logic [StatusWidth-1:0] StatusDropped = 2'd3;

   localparam logic [CsrIdxWidth-1:0] CsrAccLength    = 4'd0;
   localparam logic [CsrIdxWidth-1:0] CsrPayloadBytes = 4'd1;
   localparam logic [CsrIdxWidth-1:0] CsrStartMode    = 4'd2;
   localparam logic [CsrIdxWidth-1:0] CsrStartCount   = 4'd3;

   localparam logic [AccWidth-1:0]   AccLengthReset    = 10'd25;
   localparam logic [PayWidth-1:0]   PayloadBytesReset = 16'd4096;
   localparam logic [CountWidth-1:0] StartCountReset   = '0;

   typedef struct packed {
      logic [AccWidth-1:0]   acc_length;
      logic [PayWidth-1:0]   payload_bytes;
      logic                  start_mode;
      logic [CountWidth-1:0] start_count;
   } cfg_type;

   typedef struct packed {
      logic                drop;
      logic [SeqWidth-1:0] seq;
   } item_type;

   typedef struct packed {
      logic                start;
      logic [DivBits-1:0]  dividend;
      logic [AccWidth-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [DivBits-1:0]  quo;
      logic [AccWidth-1:0] rem;
   } div_rsp_type;

endpackage

[sv/packet_seq_to_byte_offset_core.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  raw_sequence[63:0]
// rsp_      out        rsp_valid / rsp_stall  byte_offset[63:0] signed, payload_size[15:0],
//                                             status[1:0]
// csr_      in         csr_valid / csr_ready  csr_index[3:0], csr_data[63:0]
//
// A kept word's processing time is set by the 55-step iterative divider. A raise that
// wraps the sum runs the divider twice; a dropped word bypasses the divider.
// Reset is synchronous and clears the alignment offset and the registers to
// their defaults; there is no clearing pass.
// A small queue decouples input from processing, so req_stall rises only when
// it is full; a stalled result holds the processing side at its final step.

module packet_seq_to_byte_offset_core #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [psbo_pkg::SeqWidth-1:0]          req_raw_sequence,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [psbo_pkg::SeqWidth-1:0]   rsp_byte_offset,
   output logic [psbo_pkg::PayWidth-1:0]          rsp_payload_size,
   output logic [psbo_pkg::StatusWidth-1:0]       rsp_status,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [psbo_pkg::CsrIdxWidth-1:0]       csr_index,
   input  logic [psbo_pkg::SeqWidth-1:0]          csr_data
);

   psbo_pkg::cfg_type     cfg_ff, cfg_in;
   logic                  csr_write;
   logic                  q_full;
   logic                  q_push;
   psbo_pkg::item_type    q_push_item;
   logic                  q_pop;
   psbo_pkg::item_type    q_head;
   logic                  q_valid;
   psbo_pkg::div_req_type div_req;
   psbo_pkg::div_rsp_type div_rsp;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            psbo_pkg::CsrAccLength: begin
               cfg_in.acc_length = csr_data[psbo_pkg::AccWidth-1:0];
            end
            psbo_pkg::CsrPayloadBytes: begin
               cfg_in.payload_bytes = csr_data[psbo_pkg::PayWidth-1:0];
            end
            psbo_pkg::CsrStartMode: begin
               cfg_in.start_mode = csr_data[0];
            end
            psbo_pkg::CsrStartCount: begin
               cfg_in.start_count = csr_data[psbo_pkg::CountWidth-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.acc_length    <= psbo_pkg::AccLengthReset;
         cfg_ff.payload_bytes <= psbo_pkg::PayloadBytesReset;
         cfg_ff.start_mode    <= 1'b0;
         cfg_ff.start_count   <= psbo_pkg::StartCountReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   psbo_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_raw_sequence (req_raw_sequence),
      .cfg              (cfg_ff),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_item           (q_push_item)
   );

   psbo_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .pop       (q_pop),
      .head_item (q_head),
      .not_empty (q_valid),
      .full      (q_full)
   );

   psbo_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   psbo_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_valid          (q_valid),
      .q_item           (q_head),
      .q_pop            (q_pop),
      .div_req          (div_req),
      .div_rsp          (div_rsp),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_payload_size (rsp_payload_size),
      .rsp_status       (rsp_status)
   );

endmodule

[sv/psbo_front.sv]
`timescale 1ns / 1ps

module psbo_front (
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [psbo_pkg::SeqWidth-1:0]       req_raw_sequence,
   input  psbo_pkg::cfg_type                   cfg,
   input  logic                                q_full,
   output logic                                q_push,
   output psbo_pkg::item_type                  q_item
);

   logic [psbo_pkg::SeqWidth-1:0] start_ext;
   logic                          below_start;

   assign start_ext   = {1'b0, cfg.start_count};
   assign below_start = req_raw_sequence < start_ext;

   assign req_stall   = q_full;
   assign q_push      = req_valid && !q_full;

   // A word below the start count is only marked here; the back end still
   // answers it in order with the other transactions.
   assign q_item.drop = cfg.start_mode && below_start;
   assign q_item.seq  = cfg.start_mode ? (req_raw_sequence - start_ext) : req_raw_sequence;

endmodule

[sv/psbo_queue.sv]
`timescale 1ns / 1ps

module psbo_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  psbo_pkg::item_type push_item,
   input  logic               pop,
   output psbo_pkg::item_type head_item,
   output logic               not_empty,
   output logic               full
);

   localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

   psbo_pkg::item_type  mem_ff [DEPTH];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign not_empty = count_ff != '0;
   assign full      = count_ff == FullCnt;
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCnt)
      else $error("queue fill count exceeds its depth");

endmodule

[sv/psbo_div.sv]
`timescale 1ns / 1ps

module psbo_div (
   input  logic                   clock,
   input  logic                   reset,
   input  psbo_pkg::div_req_type  req,
   output psbo_pkg::div_rsp_type  rsp
);

   localparam logic [psbo_pkg::DivCntWidth-1:0] LastStep =
      psbo_pkg::DivCntWidth'(psbo_pkg::DivBits - 1);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [psbo_pkg::DivCntWidth-1:0]    cnt_ff, cnt_in;
   logic [psbo_pkg::DivBits-1:0]        quo_ff, quo_in;
   logic [psbo_pkg::AccWidth-1:0]       rem_ff, rem_in;
   logic [psbo_pkg::AccWidth-1:0]       dsr_ff, dsr_in;
   logic [psbo_pkg::AccWidth:0]         trial;
   logic                                fits;

   // Restoring division, one quotient bit a cycle; the dividend shifts out
   // of the top of the quotient register as quotient bits shift in.
   assign trial = {rem_ff, quo_ff[psbo_pkg::DivBits-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = LastStep;
         quo_in  = req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[psbo_pkg::DivBits-2:0], fits};
         rem_in = fits ? psbo_pkg::AccWidth'(trial - {1'b0, dsr_ff})
                       : trial[psbo_pkg::AccWidth-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;
   assign rsp.rem  = rem_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < dsr_ff))
      else $error("division remainder not below the divisor");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff)
      else $error("division started while busy");

endmodule

[sv/psbo_back.sv]
`timescale 1ns / 1ps

module psbo_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  psbo_pkg::cfg_type                     cfg,
   input  logic                                  q_valid,
   input  psbo_pkg::item_type                    q_item,
   output logic                                  q_pop,
   output psbo_pkg::div_req_type                 div_req,
   input  psbo_pkg::div_rsp_type                 div_rsp,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [psbo_pkg::SeqWidth-1:0]  rsp_byte_offset,
   output logic [psbo_pkg::PayWidth-1:0]         rsp_payload_size,
   output logic [psbo_pkg::StatusWidth-1:0]      rsp_status
);

   localparam int unsigned SW = psbo_pkg::SeqWidth;
   localparam int unsigned MulWidth = 32 + psbo_pkg::PayWidth;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SUM    = 3'd1;
   localparam logic [2:0] ST_START  = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_MUL_LO = 3'd4;
   localparam logic [2:0] ST_MUL_HI = 3'd5;
   localparam logic [2:0] ST_ADD    = 3'd6;
   localparam logic [2:0] ST_OUT    = 3'd7;

   logic [2:0]                          state_ff, state_in;
   logic [SW-1:0]                       off_ff, off_in;
   logic                                pass2_ff, pass2_in;
   logic [SW-1:0]                       seq_ff, seq_in;
   logic [SW-1:0]                       sum_ff, sum_in;
   logic                                neg_ff, neg_in;
   logic [psbo_pkg::UnitShift-1:0]      low_ff, low_in;
   logic [SW-1:0]                       quo_ff, quo_in;
   logic [psbo_pkg::StatusWidth-1:0]    status_ff, status_in;
   logic [MulWidth-1:0]                 plo_ff, plo_in;
   logic [31:0]                         phi_ff, phi_in;
   logic [SW-1:0]                       res_ff, res_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]                       rsp_offset_ff, rsp_offset_in;
   logic [psbo_pkg::PayWidth-1:0]       rsp_size_ff, rsp_size_in;
   logic [psbo_pkg::StatusWidth-1:0]    rsp_status_ff, rsp_status_in;

   logic [psbo_pkg::AccWidth-1:0]       acc_eff;
   logic [psbo_pkg::IncWidth-1:0]       inc;
   logic [SW-1:0]                       mag;
   logic [psbo_pkg::IncWidth-1:0]       rmag;
   logic [psbo_pkg::IncWidth-1:0]       raise;
   logic [SW-1:0]                       qmag;
   logic [SW-1:0]                       qsig;
   logic [SW-1:0]                       raised_sum;
   logic [31:0]                         mul_a;
   logic [MulWidth-1:0]                 mul_p;
   logic                                out_free;

   assign acc_eff = (cfg.acc_length == '0) ? psbo_pkg::AccWidth'(1) : cfg.acc_length;
   assign inc     = {acc_eff, {psbo_pkg::UnitShift{1'b0}}};

   // The increment is 512 times the count, so the low nine bits of the
   // magnitude pass straight into the remainder and only the rest is divided.
   assign mag  = sum_ff[SW-1] ? (SW'(0) - sum_ff) : sum_ff;
   assign rmag = {div_rsp.rem, low_ff};
   assign raise = inc - rmag;
   assign qmag = {{psbo_pkg::UnitShift{1'b0}}, div_rsp.quo};
   assign qsig = neg_ff ? (SW'(0) - qmag) : qmag;
   assign raised_sum = sum_ff + SW'(raise);

   assign div_req.start    = state_ff == ST_START;
   assign div_req.dividend = mag[SW-1:psbo_pkg::UnitShift];
   assign div_req.divisor  = acc_eff;

   // One 32 by 16 multiplier serves both halves of the quotient.
   assign mul_a = (state_ff == ST_MUL_LO) ? quo_ff[31:0] : quo_ff[SW-1:32];
   assign mul_p = MulWidth'(mul_a) * MulWidth'(cfg.payload_bytes);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop    = (state_ff == ST_IDLE) && q_valid;

   always_comb begin
      state_in      = state_ff;
      off_in        = off_ff;
      pass2_in      = pass2_ff;
      seq_in        = seq_ff;
      sum_in        = sum_ff;
      neg_in        = neg_ff;
      low_in        = low_ff;
      quo_in        = quo_ff;
      status_in     = status_ff;
      plo_in        = plo_ff;
      phi_in        = phi_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_offset_in = rsp_offset_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               seq_in   = q_item.seq;
               pass2_in = 1'b0;
               if (q_item.drop) begin
                  res_in    = '1;
                  status_in = psbo_pkg::StatusDropped;
                  state_in  = ST_OUT;
               end else begin
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            sum_in   = seq_ff + off_ff;
            state_in = ST_START;
         end
         ST_START: begin
            neg_in   = sum_ff[SW-1];
            low_in   = mag[psbo_pkg::UnitShift-1:0];
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_MUL_LO;
               quo_in   = qsig;
               if (pass2_ff) begin
                  // Second division after a raise that wrapped the sum:
                  // only its quotient counts.
                  pass2_in = 1'b0;
               end else if (rmag == '0) begin
                  status_in = psbo_pkg::StatusAligned;
               end else if (neg_ff || (sum_ff < SW'(inc))) begin
                  status_in = psbo_pkg::StatusLowered;
                  off_in    = neg_ff ? (off_ff + SW'(rmag)) : (off_ff - SW'(rmag));
               end else begin
                  status_in = psbo_pkg::StatusRaised;
                  off_in    = off_ff + SW'(raise);
                  if (raised_sum[SW-1]) begin
                     pass2_in = 1'b1;
                     state_in = ST_SUM;
                  end else begin
                     quo_in = qmag + SW'(1);
                  end
               end
            end
         end
         ST_MUL_LO: begin
            plo_in   = mul_p;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            phi_in   = mul_p[31:0];
            state_in = ST_ADD;
         end
         ST_ADD: begin
            res_in   = SW'(plo_ff) + {phi_ff, 32'd0};
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_offset_in = res_ff;
               rsp_size_in   = cfg.payload_bytes;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         off_ff       <= '0;
         pass2_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         off_ff       <= off_in;
         pass2_ff     <= pass2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff        <= seq_in;
      sum_ff        <= sum_in;
      neg_ff        <= neg_in;
      low_ff        <= low_in;
      quo_ff        <= quo_in;
      status_ff     <= status_in;
      plo_ff        <= plo_in;
      phi_ff        <= phi_in;
      res_ff        <= res_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_byte_offset  = rsp_offset_ff;
   assign rsp_payload_size = rsp_size_ff;
   assign rsp_status       = rsp_status_ff;

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from an empty queue");

   a_offset_idle_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> $stable(off_ff))
      else $error("alignment offset changed outside the division step");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("division finished while not awaited");

endmodule

[tb/sv/packet_seq_to_byte_offset_core_tb.sv]
`timescale 1ns / 1ps

module packet_seq_to_byte_offset_core_tb;

   localparam int unsigned IdleLimit    = 20000;
   localparam int unsigned DrainCycles  = 300;
   localparam int unsigned RandomPhases = 8;
   localparam int unsigned PhaseItems   = 200;

   typedef struct packed {
      logic [psbo_pkg::SeqWidth-1:0]    byte_offset;
      logic [psbo_pkg::PayWidth-1:0]    payload_size;
      logic [psbo_pkg::StatusWidth-1:0] status;
   } offset_result_type;

   typedef enum logic [1:0] {
      StallNone,
      StallLight,
      StallHeavy,
      StallBursty
   } stall_mode_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic [psbo_pkg::SeqWidth-1:0]        req_raw_sequence = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic signed [psbo_pkg::SeqWidth-1:0] rsp_byte_offset;
   logic [psbo_pkg::PayWidth-1:0]        rsp_payload_size;
   logic [psbo_pkg::StatusWidth-1:0]     rsp_status;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [psbo_pkg::CsrIdxWidth-1:0]     csr_index = '0;
   logic [psbo_pkg::SeqWidth-1:0]        csr_data = '0;

   // Shadow copy of the block's registers and alignment offset.
   logic [psbo_pkg::AccWidth-1:0]   shadow_acc_length    = psbo_pkg::AccLengthReset;
   logic [psbo_pkg::PayWidth-1:0]   shadow_payload_bytes = psbo_pkg::PayloadBytesReset;
   logic                            shadow_start_mode    = 1'b0;
   logic [psbo_pkg::CountWidth-1:0] shadow_start_count   = psbo_pkg::StartCountReset;
   logic [psbo_pkg::SeqWidth-1:0]   shadow_offset        = '0;

   offset_result_type             expected_offsets[$];
   int unsigned                   failure_count = 0;
   int unsigned                   idle_cycles = 0;
   bit                            sender_paced = 1'b1;
   int unsigned                   burst_left = 0;
   stall_mode_type                stall_mode = StallNone;
   int unsigned                   stall_hold = 0;

   packet_seq_to_byte_offset_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_raw_sequence (req_raw_sequence),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_payload_size (rsp_payload_size),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Works out the result of one sequence word and advances the shadow offset.
   function automatic offset_result_type predict_byte_offset(
      input logic [psbo_pkg::SeqWidth-1:0] raw_word);
      offset_result_type             res;
      logic [psbo_pkg::SeqWidth-1:0] step;
      logic [psbo_pkg::SeqWidth-1:0] word;
      longint                        sum;
      longint                        rem;
      longint                        quo;
      step = 64'(shadow_acc_length == '0 ? 10'd1 : shadow_acc_length) << psbo_pkg::UnitShift;
      word = raw_word;
      res.payload_size = shadow_payload_bytes;
      res.status = psbo_pkg::StatusAligned;
      if (shadow_start_mode && raw_word < {1'b0, shadow_start_count}) begin
         res.byte_offset = '1;
         res.status = psbo_pkg::StatusDropped;
         return res;
      end
      if (shadow_start_mode) word = raw_word - {1'b0, shadow_start_count};
      sum = longint'(word + shadow_offset);
      rem = sum % longint'(step);
      if (rem != 0) begin
         // Any negative sum lands below the increment and is pulled down.
         if (sum < longint'(step)) begin
            shadow_offset = shadow_offset - $unsigned(rem);
            res.status = psbo_pkg::StatusLowered;
         end else begin
            shadow_offset = shadow_offset + step - $unsigned(rem);
            res.status = psbo_pkg::StatusRaised;
         end
         sum = longint'(word + shadow_offset);
      end
      quo = sum / longint'(step);
      res.byte_offset = $unsigned(quo) * 64'(shadow_payload_bytes);
      return res;
   endfunction

   task automatic send_sequence_word(input logic [psbo_pkg::SeqWidth-1:0] word);
      int unsigned gap;
      if (sender_paced && burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 4);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left != 0) burst_left--;
      req_valid <= 1'b1;
      req_raw_sequence <= word;
      do @(posedge clock); while (req_stall);
      expected_offsets.push_back(predict_byte_offset(word));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_offsets.size() != 0);
   endtask

   // Leaves csr_valid high so that back-to-back writes run without csr_valid dropping.
   task automatic write_register(input logic [psbo_pkg::CsrIdxWidth-1:0] index,
                                 input logic [psbo_pkg::SeqWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         psbo_pkg::CsrAccLength:    shadow_acc_length = data[psbo_pkg::AccWidth-1:0];
         psbo_pkg::CsrPayloadBytes: shadow_payload_bytes = data[psbo_pkg::PayWidth-1:0];
         psbo_pkg::CsrStartMode:    shadow_start_mode = data[0];
         psbo_pkg::CsrStartCount:   shadow_start_count = data[psbo_pkg::CountWidth-1:0];
         default: ;
      endcase
   endtask

   // Bits above each field carry random junk that the block must mask off.
   task automatic apply_settings(input logic [psbo_pkg::AccWidth-1:0] acc,
                                 input logic [psbo_pkg::PayWidth-1:0] pay,
                                 input logic mode,
                                 input logic [psbo_pkg::CountWidth-1:0] count);
      wait_drained();
      write_register(psbo_pkg::CsrAccLength,
                     ({$urandom, $urandom} << psbo_pkg::AccWidth) | 64'(acc));
      write_register(psbo_pkg::CsrPayloadBytes,
                     ({$urandom, $urandom} << psbo_pkg::PayWidth) | 64'(pay));
      write_register(psbo_pkg::CsrStartMode, ({$urandom, $urandom} << 1) | 64'(mode));
      write_register(psbo_pkg::CsrStartCount, {1'($urandom_range(0, 1)), count});
      csr_valid <= 1'b0;
   endtask

   task automatic test_default_settings();
      send_sequence_word(64'd0);
      send_sequence_word(64'd38400);
      send_sequence_word(64'd38405);
      send_sequence_word(64'd5);
      send_sequence_word(64'hFFFF_FFFF_FFFF_FFFF);
      send_sequence_word(64'h8000_0000_0000_0000);
      send_sequence_word(64'h7FFF_FFFF_FFFF_FFFF);
   endtask

   task automatic test_register_extremes();
      // A zero accumulation count acts as one; a zero payload gives offset zero.
      apply_settings(10'd0, 16'd0, 1'b0, 63'd0);
      send_sequence_word(64'h1234_5678_9ABC_DEF1);
      send_sequence_word(64'hFFFF_FFFF_FFFF_FE00);
      apply_settings(10'd1023, 16'hFFFF, 1'b1, '1);
      send_sequence_word(64'h7FFF_FFFF_FFFF_FFFE);
      send_sequence_word(64'h7FFF_FFFF_FFFF_FFFF);
      send_sequence_word(64'hFFFF_FFFF_FFFF_FFFF);
      apply_settings(10'd1, 16'd1, 1'b0, 63'd0);
      send_sequence_word(64'h0000_0000_0000_0201);
   endtask

   task automatic test_start_threshold();
      apply_settings(10'd25, 16'd4096, 1'b1, 63'd1_000_000);
      send_sequence_word(64'd999_999);
      send_sequence_word(64'd1_000_000);
      send_sequence_word(64'd1_012_800);
      send_sequence_word(64'd0);
   endtask

   task automatic test_ignored_indexes();
      apply_settings(10'd7, 16'd1500, 1'b1, 63'd100);
      for (int idx = 4; idx < 2 ** psbo_pkg::CsrIdxWidth; idx++) begin
         write_register(psbo_pkg::CsrIdxWidth'(idx), {$urandom, $urandom});
      end
      csr_valid <= 1'b0;
      send_sequence_word(64'd99);
      send_sequence_word(64'd7285);
   endtask

   task automatic test_random_traffic();
      logic [psbo_pkg::SeqWidth-1:0]   seq_word;
      logic [psbo_pkg::SeqWidth-1:0]   inc_bytes;
      logic [psbo_pkg::SeqWidth-1:0]   word;
      logic [psbo_pkg::AccWidth-1:0]   acc;
      logic [psbo_pkg::PayWidth-1:0]   pay;
      logic                            mode;
      logic [psbo_pkg::CountWidth-1:0] count;
      int unsigned                     seq_left;
      int unsigned                     pick;
      for (int phase = 0; phase < RandomPhases; phase++) begin
         case (phase)
            0: begin
               acc = 10'd1;
               pay = 16'd1;
               mode = 1'b0;
               count = '0;
            end
            1: begin
               acc = 10'd1023;
               pay = 16'hFFFF;
               mode = 1'b1;
               count = '1;
            end
            default: begin
               pick = $urandom_range(0, 3);
               acc = (pick == 0) ? 10'd0 : (pick == 1) ? 10'd1023 :
                     psbo_pkg::AccWidth'($urandom_range(1, 1023));
               pick = $urandom_range(0, 3);
               pay = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                     psbo_pkg::PayWidth'($urandom_range(1, 65535));
               mode = 1'($urandom_range(0, 1));
               pick = $urandom_range(0, 2);
               count = (pick == 0) ? psbo_pkg::CountWidth'($urandom_range(0, 100000)) :
                       (pick == 1) ? psbo_pkg::CountWidth'({$urandom, $urandom}) : '1;
            end
         endcase
         apply_settings(acc, pay, mode, count);
         sender_paced = (phase % 3) != 2;
         inc_bytes = 64'(acc == '0 ? 10'd1 : acc) << psbo_pkg::UnitShift;
         seq_left = 0;
         for (int n = 0; n < PhaseItems; n++) begin
            // Mostly runs of consecutive packets, which stay aligned once locked.
            if (seq_left == 0) begin
               seq_left = $urandom_range(1, 40);
               pick = $urandom_range(0, 3);
               case (pick)
                  0: seq_word = {$urandom, $urandom};
                  1: seq_word = 64'($urandom);
                  2: seq_word = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1 << 20));
                  default: seq_word = {1'b0, count} + 64'($urandom);
               endcase
            end
            seq_left--;
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
               word = {$urandom, $urandom};
            end else if (pick < 16 && mode && count != '0) begin
               word = {$urandom, $urandom} % {1'b0, count};
            end else begin
               word = seq_word;
               pick = $urandom_range(0, 19);
               if (pick == 0) seq_word = seq_word + 64'($urandom_range(1, 511));
               else if (pick == 1) seq_word = seq_word + inc_bytes * $urandom_range(2, 8);
               else if (pick != 2) seq_word = seq_word + inc_bytes;
            end
            send_sequence_word(word);
            if ($urandom_range(0, 199) == 0) wait_drained();
         end
      end
   endtask

   always @(posedge clock) begin
      if (stall_hold == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_hold <= $urandom_range(20, 400);
      end else begin
         stall_hold <= stall_hold - 1;
      end
      case (stall_mode)
         StallNone:  rsp_stall <= 1'b0;
         StallLight: rsp_stall <= ($urandom_range(0, 3) == 0);
         StallHeavy: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:    rsp_stall <= stall_hold[4];
      endcase
   end

   always @(posedge clock) begin : check_results
      offset_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_offsets.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual offset %h status %0d",
                     $time, rsp_byte_offset, rsp_status);
            failure_count++;
         end else begin
            want = expected_offsets.pop_front();
            if (rsp_byte_offset !== want.byte_offset) begin
               $display("%0t: byte_offset mismatch, expected %h, actual %h",
                        $time, want.byte_offset, rsp_byte_offset);
               failure_count++;
            end
            if (rsp_payload_size !== want.payload_size) begin
               $display("%0t: payload_size mismatch, expected %0d, actual %0d",
                        $time, want.payload_size, rsp_payload_size);
               failure_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, want.status, rsp_status);
               failure_count++;
            end
         end
      end
   end

   // Counts cycles without any transaction on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_default_settings();
      test_register_extremes();
      test_start_threshold();
      test_ignored_indexes();
      test_random_traffic();
      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (failure_count == 0 && expected_offsets.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
